### rtl/seconds_clock_calendar_core_defines.svh
// ----------------------------------------------------------------------------
// Seconds clock calendar: assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SECONDS_CLOCK_CALENDAR_CORE_DEFINES_SVH
`define SECONDS_CLOCK_CALENDAR_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define SCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/scc_pkg.sv
// ----------------------------------------------------------------------------
// Seconds clock calendar package
// Payload types, controller/datapath command and status, calendar constants.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int SecondsWidthDef = 36;
  localparam int SecondsWidthMax = 48;
  localparam int SetWidth        = 36;
  localparam int RemWidth        = 18;

  localparam int SecPerDay       = 86400;
  localparam int SecPerHour      = 3600;
  localparam int SecPerMin       = 60;
  localparam int DaysPerWeek     = 7;
  localparam int DaysPerEra      = 146097;
  localparam int YearsPerEra     = 400;
  localparam int EpochYear       = 1970;
  localparam int EpochYearMod400 = 370;
  localparam int EpochWeekday    = 4;
  localparam int DaysInYear      = 365;
  localparam int DaysInLeapYear  = 366;

  localparam logic [3:0] FebIdx       = 4'd1;
  localparam logic [3:0] LastMonthIdx = 4'd11;

  localparam logic KindTick = 1'b0;
  localparam logic KindSet  = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [SetWidth-1:0] set_seconds;
  } scc_in_t;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [12:0] year;
    logic [2:0]  weekday;
  } scc_out_t;

  typedef enum logic [2:0] {
    DivDay,
    DivHour,
    DivMin,
    DivWeek,
    DivEra
  } div_sel_e;

  typedef struct packed {
    logic     load_set;
    logic     count_inc;
    logic     div_load;
    logic     div_step;
    logic     capture;
    div_sel_e div_sel;
    logic     year_step;
    logic     month_step;
    logic     out_load;
  } scc_cmd_t;

  typedef struct packed {
    logic div_last;
    logic year_fits;
    logic month_fits;
  } scc_status_t;

  // Gregorian rule evaluated on the year modulo 400.
  function automatic logic is_leap(logic [8:0] y400);
    logic by4;
    logic century;
    by4     = (y400[1:0] == 2'b00);
    century = (y400 == 9'd100) || (y400 == 9'd200) || (y400 == 9'd300);
    return (by4 && !century) || (y400 == 9'd0);
  endfunction

  // Month index counts from 0 for January.
  function automatic logic [4:0] month_days(logic [3:0] m, logic leap);
    logic [4:0] len;
    if (m == FebIdx) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m inside {4'd3, 4'd5, 4'd8, 4'd10}) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

### rtl/scc_ctrl.sv
// ----------------------------------------------------------------------------
// Seconds clock calendar controller
// Sequences the division passes, year walk, month walk and result hand-off.
// ----------------------------------------------------------------------------
`include "seconds_clock_calendar_core_defines.svh"

module scc_ctrl
  import scc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        kind_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output scc_cmd_t    cmd_o,
  input  scc_status_t status_i
);

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StRun,
    StCapt,
    StYear,
    StMonth,
    StOut
  } state_e;

  state_e   state_q, state_d;
  div_sel_e sel_q, sel_d;
  logic     known_q, known_d;
  logic     out_valid_q, out_valid_d;

  function automatic div_sel_e next_sel(div_sel_e s);
    div_sel_e n;
    case (s)
      DivDay:  n = DivHour;
      DivHour: n = DivMin;
      DivMin:  n = DivWeek;
      DivWeek: n = DivEra;
      default: n = DivEra;
    endcase
    return n;
  endfunction

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    sel_d         = sel_q;
    known_d       = known_q;
    out_valid_d   = out_valid_q & ~out_ready_i;
    cmd_o         = '0;
    cmd_o.div_sel = sel_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (kind_i == KindSet) begin
            cmd_o.load_set = 1'b1;
            known_d        = 1'b1;
          end else if (known_q) begin
            cmd_o.count_inc = 1'b1;
            sel_d           = DivDay;
            state_d         = StLoad;
          end
        end
      end
      StLoad: begin
        cmd_o.div_load = 1'b1;
        state_d        = StRun;
      end
      StRun: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = StCapt;
        end
      end
      StCapt: begin
        cmd_o.capture = 1'b1;
        if (sel_q == DivEra) begin
          state_d = StYear;
        end else begin
          sel_d   = next_sel(sel_q);
          state_d = StLoad;
        end
      end
      StYear: begin
        if (status_i.year_fits) begin
          state_d = StMonth;
        end else begin
          cmd_o.year_step = 1'b1;
        end
      end
      StMonth: begin
        if (status_i.month_fits) begin
          state_d = StOut;
        end else begin
          cmd_o.month_step = 1'b1;
        end
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      sel_q       <= DivDay;
      known_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      known_q     <= known_d;
      out_valid_q <= out_valid_d;
    end
  end

  `SCC_ASSERT(a_no_overwrite, cmd_o.out_load |-> (!out_valid_q || out_ready_i), "result overwritten")
  `SCC_ASSERT_NEXT(a_unknown_tick_ignored, in_valid_i && in_ready_o && kind_i == KindTick && !known_q, state_q == StIdle, "tick processed while time unknown")
  `SCC_ASSERT(a_known_from_set, $rose(known_q) |-> $past(in_valid_i && in_ready_o && kind_i == KindSet), "time marked known without a set")

endmodule

### rtl/scc_datapath.sv
// ----------------------------------------------------------------------------
// Seconds clock calendar datapath
// Seconds count, shared reciprocal-multiply constant divider, year and month
// walkers.
// ----------------------------------------------------------------------------
`include "seconds_clock_calendar_core_defines.svh"

module scc_datapath
  import scc_pkg::*;
#(
  parameter int SecondsWidth = SecondsWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  scc_in_t     in_i,
  input  scc_cmd_t    cmd_i,
  output scc_status_t status_o,
  output scc_out_t    out_o
);

  localparam int DaysW  = SecondsWidth - 16;
  localparam int SodW   = 17;
  localparam int HremW  = 12;
  localparam int SliceW = 16;
  localparam int MulW   = 32;
  localparam int ProdW  = SliceW + MulW;
  localparam int Slices = (SecondsWidth + SliceW - 1) / SliceW;
  localparam int OpndW  = Slices * SliceW;
  localparam int AccW   = OpndW + MulW;
  localparam int CntW   = $clog2(Slices + 2);
  localparam int RemW1  = RemWidth + 1;
  localparam int SetPad = SecondsWidthMax - SetWidth;

  // Each reciprocal is floor(2^S / d), where S is the operand width of its pass.
  localparam logic [MulW-1:0] RecipDay  = MulW'((64'd1 << SecondsWidth) / SecPerDay);
  localparam logic [MulW-1:0] RecipHour = MulW'((64'd1 << SodW) / SecPerHour);
  localparam logic [MulW-1:0] RecipMin  = MulW'((64'd1 << HremW) / SecPerMin);
  localparam logic [MulW-1:0] RecipWeek = MulW'((64'd1 << DaysW) / DaysPerWeek);
  localparam logic [MulW-1:0] RecipEra  = MulW'((64'd1 << DaysW) / DaysPerEra);

  logic [SecondsWidth-1:0] count_q, count_d;
  logic [OpndW-1:0]        opnd_q;
  logic [SecondsWidth-1:0] dvnd_q;
  logic [AccW-1:0]         acc_q;
  logic [DaysW-1:0]        quo_q;
  logic [RemW1-1:0]        rem_q;
  logic [CntW-1:0]         div_cnt_q;

  logic [DaysW-1:0]    days_q;
  logic [SodW-1:0]     sod_q;
  logic [HremW-1:0]    hrem_q;
  logic [4:0]          hr_q;
  logic [5:0]          min_q;
  logic [5:0]          sec_q;
  logic [2:0]          wday_q;
  logic [RemWidth-1:0] days_left_q;
  logic [12:0]         year_q;
  logic [8:0]          yr400_q;
  logic [3:0]          month_q;
  scc_out_t            out_q;

  logic [SecondsWidthMax-1:0] set_ext;
  logic [SecondsWidth-1:0]    operand;
  logic [RemWidth-1:0]        divisor;
  logic [MulW-1:0]            recip;
  logic [DaysW-1:0]           quo_est;
  logic [SliceW-1:0]          slice;
  logic [ProdW-1:0]           slice_prod;
  logic [AccW-1:0]            acc_next;
  logic [RemW1-1:0]           rem_est;
  logic                       rem_over;
  logic [12:0]                era_years;
  logic                       leap;
  logic [8:0]                 diy;
  logic [4:0]                 mlen;

  assign set_ext = {{SetPad{1'b0}}, in_i.set_seconds};

  always_comb begin
    count_d = count_q;
    if (cmd_i.load_set) begin
      count_d = set_ext[SecondsWidth-1:0];
    end else if (cmd_i.count_inc) begin
      count_d = count_q + SecondsWidth'(1);
    end
  end

  // Every operand fits within its shift width, so the estimate is at most one short.
  always_comb begin
    case (cmd_i.div_sel)
      DivDay: begin
        operand = count_q;
        divisor = RemWidth'(SecPerDay);
        recip   = RecipDay;
        quo_est = DaysW'(acc_q >> SecondsWidth);
      end
      DivHour: begin
        operand = SecondsWidth'(sod_q);
        divisor = RemWidth'(SecPerHour);
        recip   = RecipHour;
        quo_est = DaysW'(acc_q >> SodW);
      end
      DivMin: begin
        operand = SecondsWidth'(hrem_q);
        divisor = RemWidth'(SecPerMin);
        recip   = RecipMin;
        quo_est = DaysW'(acc_q >> HremW);
      end
      DivWeek: begin
        operand = SecondsWidth'(days_q) + SecondsWidth'(EpochWeekday);
        divisor = RemWidth'(DaysPerWeek);
        recip   = RecipWeek;
        quo_est = DaysW'(acc_q >> DaysW);
      end
      default: begin
        operand = SecondsWidth'(days_q);
        divisor = RemWidth'(DaysPerEra);
        recip   = RecipEra;
        quo_est = DaysW'(acc_q >> DaysW);
      end
    endcase
  end

  // The operand is fed to the multiplier one slice per cycle, top slice first.
  assign slice      = opnd_q[OpndW-1 -: SliceW];
  assign slice_prod = ProdW'(slice) * ProdW'(recip);
  assign acc_next   = (acc_q << SliceW) + AccW'(slice_prod);

  // The true remainder is below twice the divisor, so the low bits are exact.
  assign rem_est  = RemW1'(dvnd_q) - RemW1'(quo_est) * RemW1'(divisor);
  assign rem_over = (rem_q >= RemW1'(divisor));

  assign era_years = quo_q[12:0] * 13'(YearsPerEra);

  assign leap = is_leap(yr400_q);
  assign diy  = leap ? 9'(DaysInLeapYear) : 9'(DaysInYear);
  assign mlen = month_days(month_q, leap);

  assign status_o.div_last   = (div_cnt_q == CntW'(Slices + 1));
  assign status_o.year_fits  = (days_left_q < RemWidth'(diy));
  assign status_o.month_fits = (month_q == LastMonthIdx) || (days_left_q < RemWidth'(mlen));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      div_cnt_q <= '0;
    end else begin
      count_q <= count_d;
      if (cmd_i.div_load) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      opnd_q <= OpndW'(operand);
      dvnd_q <= operand;
      acc_q  <= '0;
    end else if (cmd_i.div_step) begin
      if (div_cnt_q < CntW'(Slices)) begin
        opnd_q <= opnd_q << SliceW;
        acc_q  <= acc_next;
      end else if (div_cnt_q == CntW'(Slices)) begin
        quo_q <= quo_est;
        rem_q <= rem_est;
      end else if (rem_over) begin
        quo_q <= quo_q + DaysW'(1);
        rem_q <= rem_q - RemW1'(divisor);
      end
    end

    if (cmd_i.capture) begin
      case (cmd_i.div_sel)
        DivDay: begin
          days_q <= quo_q;
          sod_q  <= rem_q[SodW-1:0];
        end
        DivHour: begin
          hr_q   <= quo_q[4:0];
          hrem_q <= rem_q[HremW-1:0];
        end
        DivMin: begin
          min_q <= quo_q[5:0];
          sec_q <= rem_q[5:0];
        end
        DivWeek: begin
          wday_q <= rem_q[2:0];
        end
        default: begin
          days_left_q <= rem_q[RemWidth-1:0];
          year_q      <= 13'(EpochYear) + era_years;
          yr400_q     <= 9'(EpochYearMod400);
          month_q     <= '0;
        end
      endcase
    end else if (cmd_i.year_step) begin
      days_left_q <= days_left_q - RemWidth'(diy);
      year_q      <= year_q + 13'd1;
      yr400_q     <= (yr400_q == 9'(YearsPerEra - 1)) ? 9'd0 : yr400_q + 9'd1;
    end else if (cmd_i.month_step) begin
      days_left_q <= days_left_q - RemWidth'(mlen);
      month_q     <= month_q + 4'd1;
    end

    if (cmd_i.out_load) begin
      out_q.second       <= sec_q;
      out_q.minute       <= min_q;
      out_q.hour         <= hr_q;
      out_q.day_of_month <= days_left_q[4:0] + 5'd1;
      out_q.month        <= month_q + 4'd1;
      out_q.year         <= year_q;
      out_q.weekday      <= wday_q;
    end
  end

  assign out_o = out_q;

  `SCC_ASSERT(a_year_step_needed, cmd_i.year_step |-> !status_o.year_fits, "year walk overshot")
  `SCC_ASSERT(a_month_in_range, cmd_i.month_step |-> (month_q < LastMonthIdx), "month past December")
  `SCC_ASSERT(a_rem_reduced, cmd_i.capture |-> (rem_q < RemW1'(divisor)), "remainder not reduced")

endmodule

### rtl/seconds_clock_calendar_core.sv
// ----------------------------------------------------------------------------
// Seconds clock calendar core
// Unix seconds counter with Gregorian calendar output on each tick once time is set.
// ----------------------------------------------------------------------------
// Usage: the input channel carries transactions of two kinds. A set
// transaction loads the seconds count, marks the time known and produces no
// result; it completes in the cycle it is accepted. A tick transaction is
// dropped while the time is unknown; otherwise it advances the count and
// produces one calendar result on the output channel.
// A tick runs the division passes (day, hour, minute, weekday, era), each
// feeding S = ceil(SecondsWidth / 16) 16-bit operand slices through the
// reciprocal multiplier, then walks Y years (0 to 399) inside the 400-year
// era and M months (0 to 11). The year walk can take the largest share of a
// tick's processing, and the next transaction is accepted in the cycle after
// its result is loaded. One tick is worked on at a time; input ready is high
// only while the sequencer is idle.
// The result waits in an output register, so a stalled receiver does not
// hold off the next transaction; only a new result waits for the old one.
// Reset clears the count to zero and marks the time unknown.
// ----------------------------------------------------------------------------
module seconds_clock_calendar_core
  import scc_pkg::*;
#(
  parameter int SecondsWidth = SecondsWidthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  scc_in_t  in_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output scc_out_t out_o
);

  scc_cmd_t    cmd;
  scc_status_t status;

  scc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (in_i.kind),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  scc_datapath #(
    .SecondsWidth (SecondsWidth)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cmd_i    (cmd),
    .status_o (status),
    .out_o    (out_o)
  );

endmodule
